[src/heightmap_vertex_normal_unit_macros.svh]
// ----------------------------------------------------------------------------
// Height-grid normal unit assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HEIGHTMAP_VERTEX_NORMAL_UNIT_MACROS_SVH
`define HEIGHTMAP_VERTEX_NORMAL_UNIT_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define HVN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the same cycle as the antecedent.
`define HVN_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

[src/hvn_pkg.sv]
// ----------------------------------------------------------------------------
// Height-grid normal unit package
// Controller states, control and status structs and datapath widths.
// ----------------------------------------------------------------------------
package hvn_pkg;

  localparam int unsigned CoordW  = 10;
  localparam int unsigned HeightW = 8;
  localparam int unsigned ScaleW  = 10;
  localparam int unsigned MagW    = 11;
  localparam int unsigned SqW     = 22;
  localparam int unsigned Len2W   = 23;
  localparam int unsigned RootW   = 15;
  localparam int unsigned BitW    = 4;
  localparam int unsigned AccW    = 56;
  localparam int unsigned ProdW   = 40;
  localparam int unsigned FracSh  = 28;
  localparam logic [BitW-1:0] TopBit = 4'd14;
  localparam logic [ScaleW-1:0] ScaleReset = 10'd8;

  typedef enum logic [3:0] {
    ST_IDLE, ST_WRITE, ST_RD_L, ST_RD_R, ST_RD_U, ST_RD_D,
    ST_CAP_D, ST_SQUARE, ST_SETUP, ST_ITER, ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    ADDR_WRITE, ADDR_LEFT, ADDR_RIGHT, ADDR_UP, ADDR_DOWN
  } addr_sel_e;

  typedef enum logic [2:0] {
    CAP_NONE, CAP_LEFT, CAP_RIGHT, CAP_UP, CAP_DOWN
  } cap_sel_e;

  typedef struct packed {
    logic      load;
    logic      we;
    addr_sel_e addr_sel;
    cap_sel_e  cap_sel;
    logic      square;
    logic      setup;
    logic      iter;
  } ctrl_t;

  typedef struct packed {
    logic query;
    logic last_bit;
  } status_t;

endpackage

[src/hvn_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write address per cycle, registered read data.
// ----------------------------------------------------------------------------
module hvn_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/hvn_ctrl.sv]
// ----------------------------------------------------------------------------
// Height-grid normal unit controller
// Sequences grid writes, the four neighbour reads and the root search.
// ----------------------------------------------------------------------------
module hvn_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  hvn_pkg::status_t status_i,
  output hvn_pkg::ctrl_t   ctrl_o,
  output logic             busy,
  output logic             done_o
);

  hvn_pkg::state_e state_q, state_d;
  logic            accept;

  assign busy   = (state_q != hvn_pkg::ST_IDLE) && (state_q != hvn_pkg::ST_DONE);
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hvn_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      hvn_pkg::ST_IDLE, hvn_pkg::ST_DONE: begin
        if (accept) begin
          state_d = status_i.query ? hvn_pkg::ST_RD_L : hvn_pkg::ST_WRITE;
        end else begin
          state_d = hvn_pkg::ST_IDLE;
        end
      end
      hvn_pkg::ST_WRITE:  state_d = hvn_pkg::ST_IDLE;
      hvn_pkg::ST_RD_L:   state_d = hvn_pkg::ST_RD_R;
      hvn_pkg::ST_RD_R:   state_d = hvn_pkg::ST_RD_U;
      hvn_pkg::ST_RD_U:   state_d = hvn_pkg::ST_RD_D;
      hvn_pkg::ST_RD_D:   state_d = hvn_pkg::ST_CAP_D;
      hvn_pkg::ST_CAP_D:  state_d = hvn_pkg::ST_SQUARE;
      hvn_pkg::ST_SQUARE: state_d = hvn_pkg::ST_SETUP;
      hvn_pkg::ST_SETUP:  state_d = hvn_pkg::ST_ITER;
      hvn_pkg::ST_ITER: begin
        if (status_i.last_bit) begin
          state_d = hvn_pkg::ST_DONE;
        end
      end
      default: state_d = hvn_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o          = '0;
    ctrl_o.addr_sel = hvn_pkg::ADDR_WRITE;
    ctrl_o.cap_sel  = hvn_pkg::CAP_NONE;
    ctrl_o.load     = accept;
    done_o          = 1'b0;
    case (state_q)
      hvn_pkg::ST_WRITE:  ctrl_o.we = 1'b1;
      hvn_pkg::ST_RD_L:   ctrl_o.addr_sel = hvn_pkg::ADDR_LEFT;
      hvn_pkg::ST_RD_R: begin
        ctrl_o.addr_sel = hvn_pkg::ADDR_RIGHT;
        ctrl_o.cap_sel  = hvn_pkg::CAP_LEFT;
      end
      hvn_pkg::ST_RD_U: begin
        ctrl_o.addr_sel = hvn_pkg::ADDR_UP;
        ctrl_o.cap_sel  = hvn_pkg::CAP_RIGHT;
      end
      hvn_pkg::ST_RD_D: begin
        ctrl_o.addr_sel = hvn_pkg::ADDR_DOWN;
        ctrl_o.cap_sel  = hvn_pkg::CAP_UP;
      end
      hvn_pkg::ST_CAP_D:  ctrl_o.cap_sel = hvn_pkg::CAP_DOWN;
      hvn_pkg::ST_SQUARE: ctrl_o.square = 1'b1;
      hvn_pkg::ST_SETUP:  ctrl_o.setup = 1'b1;
      hvn_pkg::ST_ITER:   ctrl_o.iter = 1'b1;
      hvn_pkg::ST_DONE:   done_o = 1'b1;
      default: ;
    endcase
  end

endmodule

[src/hvn_datapath.sv]
// ----------------------------------------------------------------------------
// Height-grid normal unit datapath
// Height store, neighbour differences and bitwise reciprocal root search.
// ----------------------------------------------------------------------------
module hvn_datapath #(
  parameter int unsigned GRID_SIDE = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  hvn_pkg::ctrl_t                      ctrl_i,
  output hvn_pkg::status_t                    status_o,
  input  logic                                cfg_we_i,
  input  logic [hvn_pkg::ScaleW-1:0]          cfg_data_i,
  input  logic                                command_i,
  input  logic [hvn_pkg::CoordW-1:0]          column_i,
  input  logic [hvn_pkg::CoordW-1:0]          row_i,
  input  logic [hvn_pkg::HeightW-1:0]         height_value_i,
  output logic signed [15:0]                  normal_x_o,
  output logic [hvn_pkg::RootW-1:0]           normal_y_o,
  output logic signed [15:0]                  normal_z_o
);

  localparam int unsigned Depth = GRID_SIDE * GRID_SIDE;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned CW    = $clog2(GRID_SIDE);
  localparam logic [31:0] MaxC  = 32'(GRID_SIDE - 1);

  logic [hvn_pkg::ScaleW-1:0]  scale_q;
  logic [CW-1:0]               col_q, row_q;
  logic [hvn_pkg::HeightW-1:0] hval_q;
  logic [hvn_pkg::HeightW-1:0] left_q, right_q, up_q, down_q;
  logic [hvn_pkg::HeightW-1:0] rdata;
  logic [31:0]                 col_w, row_w, col_sel, row_sel, addr_w;
  logic [31:0]                 col_in, row_in;
  logic [AW-1:0]               addr;

  logic signed [8:0]           vx, vz;
  logic [hvn_pkg::HeightW-1:0] ax, az;
  logic [hvn_pkg::MagW-1:0]    vy;
  logic                        neg_x_q, neg_z_q;
  logic [15:0]                 sx_q, sz_q;
  logic [hvn_pkg::SqW-1:0]     sy_q;
  logic [hvn_pkg::Len2W-1:0]   len2_q;
  logic [hvn_pkg::AccW-1:0]    tgt_q [3];
  logic [hvn_pkg::AccW-1:0]    p_q [3];
  logic [hvn_pkg::ProdW-1:0]   q_q [3];
  logic [hvn_pkg::RootW-1:0]   r_q [3];
  logic [hvn_pkg::BitW-1:0]    bit_q;
  logic [hvn_pkg::AccW-1:0]    cand [3];
  logic [hvn_pkg::AccW-1:0]    len_sh;

  always_comb begin
    col_in = (32'(column_i) > MaxC) ? MaxC : 32'(column_i);
    row_in = (32'(row_i) > MaxC) ? MaxC : 32'(row_i);
    col_w  = 32'(col_q);
    row_w  = 32'(row_q);
    col_sel = col_w;
    row_sel = row_w;
    case (ctrl_i.addr_sel)
      hvn_pkg::ADDR_LEFT:  col_sel = (col_w == 32'd0) ? col_w : col_w - 32'd1;
      hvn_pkg::ADDR_RIGHT: col_sel = (col_w == MaxC) ? col_w : col_w + 32'd1;
      hvn_pkg::ADDR_UP:    row_sel = (row_w == 32'd0) ? row_w : row_w - 32'd1;
      hvn_pkg::ADDR_DOWN:  row_sel = (row_w == MaxC) ? row_w : row_w + 32'd1;
      default: ;
    endcase
    addr_w = row_sel * 32'(GRID_SIDE) + col_sel;
    addr   = addr_w[AW-1:0];
  end

  hvn_ram #(
    .WIDTH(hvn_pkg::HeightW),
    .DEPTH(Depth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ctrl_i.we),
    .addr_i (addr),
    .wdata_i(hval_q),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= hvn_pkg::ScaleReset;
    end else if (cfg_we_i) begin
      scale_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      col_q  <= col_in[CW-1:0];
      row_q  <= row_in[CW-1:0];
      hval_q <= height_value_i;
    end
    case (ctrl_i.cap_sel)
      hvn_pkg::CAP_LEFT:  left_q  <= rdata;
      hvn_pkg::CAP_RIGHT: right_q <= rdata;
      hvn_pkg::CAP_UP:    up_q    <= rdata;
      hvn_pkg::CAP_DOWN:  down_q  <= rdata;
      default: ;
    endcase
  end

  always_comb begin
    vx = $signed({1'b0, left_q}) - $signed({1'b0, right_q});
    vz = $signed({1'b0, up_q}) - $signed({1'b0, down_q});
    ax = vx[8] ? 8'(-vx) : vx[7:0];
    az = vz[8] ? 8'(-vz) : vz[7:0];
    vy = (scale_q == '0) ? 11'd2 : {scale_q, 1'b0};
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.square) begin
      neg_x_q <= vx[8];
      neg_z_q <= vz[8];
      sx_q    <= ax * ax;
      sz_q    <= az * az;
      sy_q    <= vy * vy;
    end
  end

  assign len_sh = hvn_pkg::AccW'(len2_q) << {bit_q, 1'b0};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cand[i] = p_q[i] + (hvn_pkg::AccW'(q_q[i]) << (5'(bit_q) + 5'd1)) + len_sh;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.setup) begin
      len2_q <= hvn_pkg::Len2W'(sx_q) + hvn_pkg::Len2W'(sy_q) + hvn_pkg::Len2W'(sz_q);
      tgt_q[0] <= hvn_pkg::AccW'(sx_q) << hvn_pkg::FracSh;
      tgt_q[1] <= hvn_pkg::AccW'(sy_q) << hvn_pkg::FracSh;
      tgt_q[2] <= hvn_pkg::AccW'(sz_q) << hvn_pkg::FracSh;
      bit_q    <= hvn_pkg::TopBit;
      for (int i = 0; i < 3; i++) begin
        p_q[i] <= '0;
        q_q[i] <= '0;
        r_q[i] <= '0;
      end
    end else if (ctrl_i.iter) begin
      bit_q <= bit_q - 4'd1;
      for (int i = 0; i < 3; i++) begin
        if (cand[i] <= tgt_q[i]) begin
          p_q[i] <= cand[i];
          q_q[i] <= q_q[i] + (hvn_pkg::ProdW'(len2_q) << bit_q);
          r_q[i] <= r_q[i] | (hvn_pkg::RootW'(1) << bit_q);
        end
      end
    end
  end

  assign status_o.query    = command_i;
  assign status_o.last_bit = (bit_q == '0);

  assign normal_x_o = neg_x_q ? -$signed({1'b0, r_q[0]}) : $signed({1'b0, r_q[0]});
  assign normal_y_o = r_q[1];
  assign normal_z_o = neg_z_q ? -$signed({1'b0, r_q[2]}) : $signed({1'b0, r_q[2]});

endmodule

[src/heightmap_vertex_normal_unit.sv]
// ----------------------------------------------------------------------------
// Height-grid vertex normal unit
// Stores an 8-bit height grid and returns unit normals by central differences.
// ----------------------------------------------------------------------------
// Channel   Direction  Beat marked by          Carries
// command   in         start high, busy low    command, column, row, height_value
// result    out        done_o high             normal_x, normal_y, normal_z
// config    in         cfg_we_i high           height_scale
//
// A write beat passes the write state and returns to idle; a query runs from
// acceptance to the done_o beat via four single-port store reads and a 15-step root search.
// A new beat may be accepted in the cycle that done_o is high.
// The height store is not cleared by reset; its entries hold nothing until written.
// ----------------------------------------------------------------------------
`include "heightmap_vertex_normal_unit_macros.svh"

module heightmap_vertex_normal_unit #(
  parameter int unsigned GRID_SIDE = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               command_i,
  input  logic [9:0]         column_i,
  input  logic [9:0]         row_i,
  input  logic [7:0]         height_value_i,
  input  logic               cfg_we_i,
  input  logic [9:0]         cfg_data_i,
  output logic               done_o,
  output logic signed [15:0] normal_x_o,
  output logic [14:0]        normal_y_o,
  output logic signed [15:0] normal_z_o
);

  hvn_pkg::ctrl_t   ctrl;
  hvn_pkg::status_t status;

  hvn_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .status_i(status),
    .ctrl_o  (ctrl),
    .busy    (busy),
    .done_o  (done_o)
  );

  hvn_datapath #(
    .GRID_SIDE(GRID_SIDE)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .status_o      (status),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .command_i     (command_i),
    .column_i      (column_i),
    .row_i         (row_i),
    .height_value_i(height_value_i),
    .normal_x_o    (normal_x_o),
    .normal_y_o    (normal_y_o),
    .normal_z_o    (normal_z_o)
  );

  `HVN_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `HVN_ASSERT_NEXT(a_single_done, done_o, !done_o)
  `HVN_ASSERT_SAME(a_done_after_work, done_o, $past(busy))

endmodule
